// ===== rtl/gbte_pkg.sv =====
`default_nettype none
package gbte_pkg;

    localparam int IN_BYTES  = 22;  // 171 bits of tdata padded to bytes
    localparam int OUT_BYTES = 16;  // 122 bits of tdata padded to bytes

    typedef enum logic [1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_GET     = 2'd2,
        MODE_STEP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_GX = 2'd0,
        CFG_GY = 2'd1,
        CFG_GZ = 2'd2
    } cfg_idx_t;

    localparam logic signed [31:0] GRAVITY_Y_RESET = -32'sd642908;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREATE_RD,
        S_CREATE_WR,
        S_LOOKUP,
        S_HANDLE,
        S_STEP_RD,
        S_STEP_VEL,
        S_STEP_POS,
        S_STEP_WR,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic pop_rd;
        logic create_wr;
        logic destroy_wr;
        logic get_load;
        logic stale_out;
        logic full_out;
        logic step_clr;
        logic step_vel;
        logic step_pos;
        logic step_wr;
        logic clr_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  can_pop;
        logic  can_append;
        logic  handle_ok;
        logic  step_done;
    } sts_t;

    // saturate a 34 bit sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -34'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gbte_ctrl.sv =====
`default_nettype none
module gbte_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic          out_taken,
    output logic               in_ready,
    output logic               out_valid,
    output gbte_pkg::cmd_t     cmd,
    input  gbte_pkg::sts_t     sts
);
    import gbte_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.clr_out = 1'b1;
                unique case (sts.mode)
                    MODE_CREATE: begin
                        if (sts.can_pop) begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_CREATE_RD;
                        end else if (sts.can_append) begin
                            state_next = S_CREATE_WR;
                        end else begin
                            cmd.full_out = 1'b1;
                            state_next   = S_OUT;
                        end
                    end
                    MODE_STEP: begin
                        cmd.step_clr = 1'b1;
                        state_next   = S_STEP_RD;
                    end
                    default: begin
                        state_next = S_HANDLE;
                    end
                endcase
            end
            S_CREATE_RD: state_next = S_CREATE_WR;
            S_CREATE_WR: begin
                cmd.create_wr = 1'b1;
                state_next    = S_OUT;
            end
            S_HANDLE: begin
                if (!sts.handle_ok)                 cmd.stale_out  = 1'b1;
                else if (sts.mode == MODE_DESTROY)  cmd.destroy_wr = 1'b1;
                else                                cmd.get_load   = 1'b1;
                state_next = S_OUT;
            end
            S_STEP_RD: begin
                if (sts.step_done) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_STEP_VEL;
                end
            end
            S_STEP_VEL: begin
                cmd.step_vel = 1'b1;
                state_next   = S_STEP_POS;
            end
            S_STEP_POS: begin
                cmd.step_pos = 1'b1;
                state_next   = S_STEP_WR;
            end
            S_STEP_WR: begin
                cmd.step_wr = 1'b1;
                state_next  = S_STEP_RD;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_taken) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // single request in flight: never ready while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn) !(in_ready && out_valid))
        else $error("ready while result pending");
    // a step run always ends through the result state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP_RD && sts.step_done) |=> state_reg == S_OUT)
        else $error("step end lost");
    // a taken result returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_taken) |=> in_ready)
        else $error("no return to idle");
endmodule
`default_nettype wire

// ===== rtl/gbte_dp.sv =====
`default_nettype none
module gbte_dp #(
    parameter int MAX_BODIES = 256,
    parameter int GEN_BITS   = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [1:0]               in_mode,
    input  wire logic signed [31:0]       in_mass,
    input  wire logic signed [31:0]       in_sx,
    input  wire logic signed [31:0]       in_sy,
    input  wire logic signed [31:0]       in_sz,
    input  wire logic                     in_hvalid,
    input  wire logic [7:0]               in_hindex,
    input  wire logic [15:0]              in_hgen,
    input  wire logic [15:0]              in_dt,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_idx,
    input  wire logic [31:0]              cfg_data,
    input  gbte_pkg::cmd_t                cmd,
    output gbte_pkg::sts_t                sts,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_index,
    output logic [15:0]                   o_gen,
    output logic signed [31:0]            o_x,
    output logic signed [31:0]            o_y,
    output logic signed [31:0]            o_z
);
    import gbte_pkg::*;

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = AW + 1;
    localparam int GW = (GEN_BITS < 16) ? GEN_BITS : 16;

    // gravity registers
    logic signed [31:0] gx_reg, gy_reg, gz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg <= '0;
            gy_reg <= GRAVITY_Y_RESET;
            gz_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_GX:  gx_reg <= cfg_data;
                CFG_GY:  gy_reg <= cfg_data;
                CFG_GZ:  gz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured request
    mode_t              mode_reg;
    logic               dyn_new_reg, hvalid_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic [7:0]         hidx_reg;
    logic [15:0]        hgen_reg, dt_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg    <= mode_t'(in_mode);
            dyn_new_reg <= in_mass > 32'sd0;
            sx_reg      <= in_sx;
            sy_reg      <= in_sy;
            sz_reg      <= in_sz;
            hvalid_reg  <= in_hvalid;
            hidx_reg    <= in_hindex;
            hgen_reg    <= in_hgen;
            dt_reg      <= in_dt;
        end
    end

    // body memories
    logic [31:0]         px_mem [MAX_BODIES];
    logic [31:0]         py_mem [MAX_BODIES];
    logic [31:0]         pz_mem [MAX_BODIES];
    logic [31:0]         vx_mem [MAX_BODIES];
    logic [31:0]         vy_mem [MAX_BODIES];
    logic [31:0]         vz_mem [MAX_BODIES];
    logic                dyn_mem [MAX_BODIES];
    logic [GEN_BITS-1:0] gen_mem [MAX_BODIES];
    logic [AW-1:0]       free_mem [MAX_BODIES];

    logic [CW-1:0] count_reg, top_reg;
    logic [CW-1:0] walk_reg;
    logic [AW-1:0] slot_reg;
    logic          from_pop_reg;

    // slot handle check
    logic [CW-1:0] hidx_ext;
    assign hidx_ext = CW'(hidx_reg);
    logic idx_ok;
    assign idx_ok = (hidx_ext < count_reg) && ((MAX_BODIES >= 256) || (hidx_reg < 8'(MAX_BODIES)));

    // read side registers
    logic [AW-1:0]       pop_q;
    logic [GEN_BITS-1:0] gen_q;
    logic                dyn_q;
    logic signed [31:0]  rpx_q, rpy_q, rpz_q, rvx_q, rvy_q, rvz_q;
    logic [AW-1:0]       raddr;
    // step walks the table, a reused slot reads its own entry, else the handle
    assign raddr = (mode_reg == MODE_STEP) ? walk_reg[AW-1:0]
                 : from_pop_reg ? pop_q : AW'(hidx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.pop_rd) pop_q <= free_mem[top_reg[AW-1:0] - AW'(1)];
        gen_q <= gen_mem[raddr];
        dyn_q <= dyn_mem[raddr];
        rpx_q <= px_mem[raddr];
        rpy_q <= py_mem[raddr];
        rpz_q <= pz_mem[raddr];
        rvx_q <= vx_mem[raddr];
        rvy_q <= vy_mem[raddr];
        rvz_q <= vz_mem[raddr];
    end

    // euler arithmetic: multiply by dt with round half up
    function automatic logic signed [33:0] mdt(input logic signed [31:0] a,
                                               input logic [15:0] dt);
        logic signed [48:0] p;
        p = a * $signed({1'b0, dt}) + 49'sd32768;
        return 34'(p >>> 16);
    endfunction

    logic signed [31:0] nvx_reg, nvy_reg, nvz_reg, npx, npy, npz;
    logic signed [33:0] mx_reg, my_reg, mz_reg;

    // counters, stack pointer and walk index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            top_reg   <= '0;
            walk_reg  <= '0;
        end else begin
            if (cmd.pop_rd) top_reg <= top_reg - CW'(1);
            if (cmd.create_wr && !from_pop_reg) count_reg <= count_reg + CW'(1);
            if (cmd.destroy_wr && top_reg < CW'(MAX_BODIES)) top_reg <= top_reg + CW'(1);
            if (cmd.step_clr) walk_reg <= '0;
            if (cmd.step_wr) walk_reg <= walk_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_rd) from_pop_reg <= 1'b1;
        else if (cmd.load_in) from_pop_reg <= 1'b0;
    end
    assign slot_reg = from_pop_reg ? pop_q : count_reg[AW-1:0];

    // memory writes
    logic [GEN_BITS-1:0] gen_new;
    assign gen_new = from_pop_reg ? gen_q : '0;
    always_ff @(posedge aclk) begin
        if (cmd.create_wr) begin
            px_mem[slot_reg]  <= sx_reg;
            py_mem[slot_reg]  <= sy_reg;
            pz_mem[slot_reg]  <= sz_reg;
            vx_mem[slot_reg]  <= '0;
            vy_mem[slot_reg]  <= '0;
            vz_mem[slot_reg]  <= '0;
            dyn_mem[slot_reg] <= dyn_new_reg;
            gen_mem[slot_reg] <= gen_new;
        end
        if (cmd.destroy_wr) begin
            dyn_mem[AW'(hidx_reg)] <= 1'b0;
            gen_mem[AW'(hidx_reg)] <= gen_q + GEN_BITS'(1);
            if (top_reg < CW'(MAX_BODIES)) free_mem[top_reg[AW-1:0]] <= AW'(hidx_reg);
        end
        if (cmd.step_wr && dyn_q) begin
            vx_mem[walk_reg[AW-1:0]] <= nvx_reg;
            vy_mem[walk_reg[AW-1:0]] <= nvy_reg;
            vz_mem[walk_reg[AW-1:0]] <= nvz_reg;
            px_mem[walk_reg[AW-1:0]] <= npx;
            py_mem[walk_reg[AW-1:0]] <= npy;
            pz_mem[walk_reg[AW-1:0]] <= npz;
        end
    end

    // step pipeline: velocity then position
    always_ff @(posedge aclk) begin
        if (cmd.step_vel) begin
            nvx_reg <= sat32(34'(rvx_q) + mdt(gx_reg, dt_reg));
            nvy_reg <= sat32(34'(rvy_q) + mdt(gy_reg, dt_reg));
            nvz_reg <= sat32(34'(rvz_q) + mdt(gz_reg, dt_reg));
        end
        if (cmd.step_pos) begin
            mx_reg <= mdt(nvx_reg, dt_reg);
            my_reg <= mdt(nvy_reg, dt_reg);
            mz_reg <= mdt(nvz_reg, dt_reg);
        end
    end
    assign npx = sat32(34'(rpx_q) + mx_reg);
    assign npy = sat32(34'(rpy_q) + my_reg);
    assign npz = sat32(34'(rpz_q) + mz_reg);

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.clr_out) begin
            o_status <= cmd.full_out ? ST_FULL : ST_OK;
            o_index  <= '0;
            o_gen    <= '0;
            o_x      <= '0;
            o_y      <= '0;
            o_z      <= '0;
        end
        if (cmd.stale_out) o_status <= ST_STALE;
        if (cmd.create_wr) begin
            o_index <= 8'(slot_reg);
            o_gen   <= 16'(gen_new);
        end
        if (cmd.get_load) begin
            o_x <= rpx_q;
            o_y <= rpy_q;
            o_z <= rpz_q;
        end
    end

    // status to controller
    assign sts.mode       = mode_reg;
    assign sts.can_pop    = top_reg != '0;
    assign sts.can_append = count_reg < CW'(MAX_BODIES);
    assign sts.handle_ok  = hvalid_reg && idx_ok
                            && (GW'(gen_q) == GW'(hgen_reg))
                            && (GEN_BITS >= 16 || hgen_reg >> GEN_BITS == 16'd0);
    assign sts.step_done  = walk_reg >= count_reg;

    // counters stay in range and a pop lowers the free stack pointer
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CW'(MAX_BODIES))
        else $error("slot count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) top_reg <= CW'(MAX_BODIES))
        else $error("free stack overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_rd |=> top_reg == $past(top_reg) - CW'(1))
        else $error("pop lost");
endmodule
`default_nettype wire

// ===== rtl/generational_body_table_euler_top.sv =====
`default_nettype none
// channel   direction  fields (low bit first)
// s_axis    in         mode, mass, start_x/y/z, handle_valid/index/generation, time_step
// m_axis    out        status, out_index, out_generation, out_x/y/z
// cfg       in         gravity_x, gravity_y, gravity_z by index
// create, destroy, get: lookup state, then result state (table full), write state
//   (append), handle state (handle check) or read and write states (freed slot reuse)
// step: lookup, then read, velocity, position and write states, one slot at a time
// after the result is taken the block returns to idle before taking the next request
// reset clears counters and restores gravity, body memories are not cleared
// one request at a time; a waiting result holds off the input until taken
module generational_body_table_euler_top #(
    parameter int MAX_BODIES = 256,
    parameter int GEN_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [gbte_pkg::IN_BYTES*8-1:0]  s_tdata,  // mode,mass,sx,sy,sz,hv,hi,hg,dt
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [gbte_pkg::OUT_BYTES*8-1:0] m_tdata,  // status,index,gen,x,y,z
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import gbte_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [1:0]  o_status;
    logic [7:0]  o_index;
    logic [15:0] o_gen;
    logic signed [31:0] o_x, o_y, o_z;

    gbte_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire  (s_tvalid && s_tready),
        .out_taken(m_tready),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .cmd, .sts
    );

    gbte_dp #(.MAX_BODIES(MAX_BODIES), .GEN_BITS(GEN_BITS)) u_dp (
        .aclk, .aresetn,
        .in_mode  (s_tdata[1:0]),
        .in_mass  (s_tdata[33:2]),
        .in_sx    (s_tdata[65:34]),
        .in_sy    (s_tdata[97:66]),
        .in_sz    (s_tdata[129:98]),
        .in_hvalid(s_tdata[130]),
        .in_hindex(s_tdata[138:131]),
        .in_hgen  (s_tdata[154:139]),
        .in_dt    (s_tdata[170:155]),
        .cfg_we, .cfg_idx(cfg_index), .cfg_data,
        .cmd, .sts,
        .o_status, .o_index, .o_gen, .o_x, .o_y, .o_z
    );

    assign m_tdata = {6'd0, o_z, o_y, o_x, o_gen, o_index, o_status};
endmodule
`default_nettype wire

// ===== tb/gbte_checker.sv =====
`default_nettype none
module gbte_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [gbte_pkg::IN_BYTES*8-1:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [gbte_pkg::OUT_BYTES*8-1:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gbte_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [7:0]         index;
        logic [15:0]        generation;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } body_reply_t;

    // gravity and body table shadow
    logic signed [31:0] grav_x, grav_y, grav_z;
    logic signed [31:0] pos_x [256], pos_y [256], pos_z [256];
    logic signed [31:0] vel_x [256], vel_y [256], vel_z [256];
    logic               dyn [256];
    logic [15:0]        gens [256];
    logic [7:0]         free_slots [256];
    int                 used_slots, free_depth;
    body_reply_t        replies_due [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("gbte_checker: %s mismatch, got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // q16.16 times unsigned q0.16, round half up
    function automatic longint scale_dt(input logic signed [31:0] v, input logic [15:0] dt);
        longint p;
        p = longint'(v) * longint'({1'b0, dt}) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic handle_ok(input logic hv, input logic [7:0] hi, input logic [15:0] hg);
        return hv && (int'(hi) < used_slots) && (gens[hi] == hg);
    endfunction

    // apply one request to the table and return its reply
    function automatic body_reply_t apply_request(input logic [175:0] v);
        body_reply_t r;
        mode_t       mode;
        logic        hv;
        logic [7:0]  hi, slot;
        logic [15:0] hg, dt;
        mode = mode_t'(v[1:0]);
        hv   = v[130];
        hi   = v[138:131];
        hg   = v[154:139];
        dt   = v[170:155];
        r    = '0;
        r.status = ST_OK;
        case (mode)
            MODE_CREATE: begin
                if (free_depth > 0) begin
                    free_depth--;
                    slot = free_slots[free_depth];
                end else if (used_slots < 256) begin
                    slot = used_slots[7:0];
                    used_slots++;
                    gens[slot] = '0;
                end else begin
                    r.status = ST_FULL;
                    return r;
                end
                pos_x[slot] = v[65:34];
                pos_y[slot] = v[97:66];
                pos_z[slot] = v[129:98];
                vel_x[slot] = '0;
                vel_y[slot] = '0;
                vel_z[slot] = '0;
                dyn[slot]   = $signed(v[33:2]) > 0;
                r.index      = slot;
                r.generation = gens[slot];
            end
            MODE_DESTROY: begin
                if (!handle_ok(hv, hi, hg)) begin
                    r.status = ST_STALE;
                    return r;
                end
                dyn[hi]  = 1'b0;
                gens[hi] = gens[hi] + 16'd1;
                if (free_depth < 256) begin
                    free_slots[free_depth] = hi;
                    free_depth++;
                end
            end
            MODE_GET: begin
                if (!handle_ok(hv, hi, hg)) begin
                    r.status = ST_STALE;
                    return r;
                end
                r.x = pos_x[hi];
                r.y = pos_y[hi];
                r.z = pos_z[hi];
            end
            default: begin
                for (int i = 0; i < used_slots; i++) begin
                    if (dyn[i]) begin
                        vel_x[i] = clamp32(longint'(vel_x[i]) + scale_dt(grav_x, dt));
                        vel_y[i] = clamp32(longint'(vel_y[i]) + scale_dt(grav_y, dt));
                        vel_z[i] = clamp32(longint'(vel_z[i]) + scale_dt(grav_z, dt));
                        pos_x[i] = clamp32(longint'(pos_x[i]) + scale_dt(vel_x[i], dt));
                        pos_y[i] = clamp32(longint'(pos_y[i]) + scale_dt(vel_y[i], dt));
                        pos_z[i] = clamp32(longint'(pos_z[i]) + scale_dt(vel_z[i], dt));
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        body_reply_t want, got;
        if (!aresetn) begin
            grav_x = '0;
            grav_y = GRAVITY_Y_RESET;
            grav_z = '0;
            used_slots = 0;
            free_depth = 0;
            fail_count = 0;
            replies_due.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GX: grav_x = cfg_data;
                    CFG_GY: grav_y = cfg_data;
                    CFG_GZ: grav_z = cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (s_tvalid && s_tready)
                replies_due = {replies_due, apply_request(176'(s_tdata))};
            // accepted reply
            if (m_tvalid && m_tready) begin
                got.status     = status_t'(m_tdata[1:0]);
                got.index      = m_tdata[9:2];
                got.generation = m_tdata[25:10];
                got.x          = m_tdata[57:26];
                got.y          = m_tdata[89:58];
                got.z          = m_tdata[121:90];
                if (replies_due.size() == 0) begin
                    report("unexpected reply", longint'(m_tdata[63:0]), 0);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status) report("status", got.status, want.status);
                    if (got.index != want.index) report("index", got.index, want.index);
                    if (got.generation != want.generation)
                        report("generation", got.generation, want.generation);
                    if (got.x != want.x) report("x", got.x, want.x);
                    if (got.y != want.y) report("y", got.y, want.y);
                    if (got.z != want.z) report("z", got.z, want.z);
                end
            end
        end
        pending = replies_due.size();
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gbte_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending;
    int          cycles = 0;
    logic        long_hold = 1'b0;
    logic        no_gaps = 1'b0;

    // stimulus-side view of handles
    int          slots_used = 0, slots_free = 0;
    logic [15:0] slot_gen [256];

    generational_body_table_euler_top dut (.*);

    gbte_checker checker_i (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 18);
    endfunction

    // receiver with random stalls and one long hold
    initial begin
        int g;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            g = draw_gap();
            if (long_hold) begin
                g = 400;
                long_hold = 1'b0;
            end
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return {16'($signed($urandom_range(0, 200)) - 100), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input mode_t mode, input logic [31:0] mass, input logic [31:0] sx,
                        input logic [31:0] sy, input logic [31:0] sz, input logic hv,
                        input logic [7:0] hi, input logic [15:0] hg, input logic [15:0] dt);
        logic [175:0] v;
        int g;
        v = {5'b0, dt, hg, hi, hv, sz, sy, sx, mass, mode};
        s_tdata  <= v[IN_BYTES*8-1:0];
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // track slot bookkeeping in request order
        if (mode == MODE_CREATE) begin
            if (slots_free > 0) slots_free--;
            else if (slots_used < 256) begin
                slot_gen[slots_used] = '0;
                slots_used++;
            end
        end else if (mode == MODE_DESTROY && hv && int'(hi) < slots_used
                     && slot_gen[hi] == hg) begin
            slot_gen[hi]++;
            if (slots_free < 256) slots_free++;
        end
        g = draw_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic create(input logic [31:0] mass);
        send(MODE_CREATE, mass, pick32(), pick32(), pick32(), 1'($urandom), 8'($urandom),
             16'($urandom), 16'($urandom));
    endtask

    task automatic handle_op(input mode_t mode, input int idx);
        send(mode, $urandom, $urandom, $urandom, $urandom, 1'b1, idx[7:0], slot_gen[idx],
             16'($urandom));
    endtask

    task automatic step(input logic [15:0] dt);
        send(MODE_STEP, $urandom, $urandom, $urandom, $urandom, 1'($urandom), 8'($urandom),
             16'($urandom), dt);
    endtask

    // quiet the input, wait for all replies, then write gravity
    task automatic set_gravity(input logic [31:0] gx, input logic [31:0] gy,
                               input logic [31:0] gz);
        if (s_tvalid) s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= CFG_GX; cfg_data <= gx;
        @(posedge aclk);
        cfg_index <= CFG_GY; cfg_data <= gy;
        @(posedge aclk);
        cfg_index <= CFG_GZ; cfg_data <= gz;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one random request, mostly well-formed handles
    task automatic random_request(input int cap);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (slots_used == 0 || (r < 30 && slots_used - slots_free < cap)) begin
            create($urandom_range(0, 3) == 0 ? pick32() : {1'b0, 31'($urandom)});
        end else if (r < 75) begin
            idx = $urandom_range(0, slots_used - 1);
            if ($urandom_range(0, 9) < 8)
                handle_op(r < 55 ? MODE_DESTROY : MODE_GET, idx);
            else
                send(r < 55 ? MODE_DESTROY : MODE_GET, $urandom, $urandom, $urandom, $urandom,
                     1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom)
                     : 16'(slot_gen[idx] + 1), 16'($urandom));
        end else if (r < 88) begin
            step($urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom));
        end else begin
            idx = $urandom_range(0, slots_used - 1);
            handle_op(MODE_GET, idx);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: creates at field extremes, steps, gets, stale handles
        no_gaps = 1'b1;
        send(MODE_GET, 0, 0, 0, 0, 1'b1, 8'd0, 16'd0, 16'd0);
        create(32'h00010000);
        send(MODE_CREATE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b0,
             8'hff, 16'hffff, 16'hffff);
        send(MODE_CREATE, 32'h0, 32'h80000000, 32'h7fffffff, 32'h0, 1'b1, 8'h0, 16'h0,
             16'h0);
        send(MODE_CREATE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h12345678, 1'b1,
             8'h0, 16'h0, 16'h0);
        step(16'hffff);
        step(16'h0000);
        step(16'h8000);
        for (int i = 0; i < 4; i++) handle_op(MODE_GET, i);
        send(MODE_GET, 0, 0, 0, 0, 1'b0, 8'd1, 16'd0, 16'd0);
        send(MODE_GET, 0, 0, 0, 0, 1'b1, 8'd200, 16'd0, 16'd0);
        handle_op(MODE_DESTROY, 1);
        send(MODE_DESTROY, 0, 0, 0, 0, 1'b1, 8'd1, 16'd0, 16'd0);
        send(MODE_GET, 0, 0, 0, 0, 1'b1, 8'd1, 16'd0, 16'd0);
        create(32'h00020000);
        handle_op(MODE_GET, 1);
        step(16'h1000);
        handle_op(MODE_GET, 3);
        no_gaps = 1'b0;

        // gravity extremes with random traffic, long receiver hold midway
        set_gravity(32'h7fffffff, 32'h80000000, 32'h00010000);
        for (int i = 0; i < 60; i++) begin
            if (i == 20) long_hold = 1'b1;
            no_gaps = (i >= 40 && i < 50);
            random_request(24);
        end
        no_gaps = 1'b0;
        set_gravity(32'h80000000, 32'h7fffffff, 32'hfff00000);
        for (int i = 0; i < 50; i++) random_request(24);

        // fill the table, overflow it, free every slot, destroy once more, then get and create again
        set_gravity(32'h0, 32'h0, 32'h0);
        while (slots_used < 256 || slots_free > 0) create($urandom);
        create(32'h00010000);
        create(32'h00010000);
        step(16'h0100);
        for (int i = 0; i < 256; i++) handle_op(MODE_DESTROY, i);
        handle_op(MODE_DESTROY, 7);
        handle_op(MODE_GET, 7);
        for (int i = 0; i < 20; i++) create($urandom_range(0, 1) ? 32'h00010000 : $urandom);

        // random x and z gravity with y near the reset value, more random traffic
        set_gravity($urandom, 32'hfff62e64, $urandom);
        for (int i = 0; i < 60; i++) random_request(300);

        if (s_tvalid) s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
